// File: design/grid_raycast_column_shader_defines.svh
`ifndef GRID_RAYCAST_COLUMN_SHADER_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_SHADER_DEFINES_SVH

// Implication checked on every clock, off during reset.
`define GRCS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GRCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/grcs_pkg.sv
package grcs_pkg;

	localparam int MAP_SIZE_DEF      = 16;
	localparam int SCREEN_HEIGHT_DEF = 40;
	localparam int MAX_STEPS_DEF     = 160;

	localparam int CELL_UNITS = 163840;
	localparam logic [31:0] COS2_Q32 = 32'd4294537814;

	localparam int MUL_AW = 66;
	localparam int MUL_BW = 34;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam int DIV_BITS = 14;

	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_FULL  = 16'h2588;
	localparam logic [15:0] CH_DARK  = 16'h2593;
	localparam logic [15:0] CH_MED   = 16'h2592;
	localparam logic [15:0] CH_LIGHT = 16'h2591;
	localparam logic [15:0] CH_HASH  = 16'h0023;
	localparam logic [15:0] CH_X     = 16'h0078;
	localparam logic [15:0] CH_DOT   = 16'h002e;
	localparam logic [15:0] CH_DASH  = 16'h002d;

endpackage

// File: design/grcs_mul.sv
module grcs_mul #(
	parameter int AW = grcs_pkg::MUL_AW,
	parameter int BW = grcs_pkg::MUL_BW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [AW-1:0]      a,
	input  logic [BW-1:0]      b,
	output logic               busy,
	output logic               done,
	output logic [AW+BW-1:0]   product
);
	localparam int PW  = AW + BW;
	localparam int DIG = (BW + 3) / 4;
	localparam int CW  = (DIG > 1) ? $clog2(DIG) : 1;

	logic [PW-1:0]    a_q;
	logic [4*DIG-1:0] b_q;
	logic [PW-1:0]    acc_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [PW-1:0]    pp;

	// radix-16 digit: four shifted copies of the multiplicand
	always_comb begin
		pp = ({PW{b_q[0]}} & a_q)
			+ (({PW{b_q[1]}} & a_q) << 1)
			+ (({PW{b_q[2]}} & a_q) << 2)
			+ (({PW{b_q[3]}} & a_q) << 3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				a_q    <= PW'(a);
				b_q    <= (4*DIG)'(b);
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_q + pp;
				a_q   <= a_q << 4;
				b_q   <= b_q >> 4;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q;

endmodule

// File: design/grid_raycast_column_shader.sv
// Grid raycast column shader.
// Input stream s_axis: one transaction per screen column, tdata holds
// column_index, pos_x, pos_y, dir_x, dir_y. Output stream m_axis: one
// transaction per screen row, top row first, tlast on the bottom row.
// Config channel cfg_*: writes the four 64-bit wall bitmap registers;
// cfg_ready is high out of reset, indexes above three are dropped.
// Work per column: capture, up to MAX_STEPS march steps (one step a cycle),
// on a wall hit 10 products plus up to 9 more for the corner test on the
// shared radix-16 multiplier, a restoring divide for the ceiling row,
// then SCREEN_HEIGHT output rows.
// s_axis_tready is high only while no column is in work and out of reset.
// A stalled receiver holds the current row in the output register and
// the row sequencer waits; nothing is dropped.
// Reset clears the wall bitmap and empties the output register.
`include "grid_raycast_column_shader_defines.svh"
module grid_raycast_column_shader #(
	parameter int MAP_SIZE      = grcs_pkg::MAP_SIZE_DEF,
	parameter int SCREEN_HEIGHT = grcs_pkg::SCREEN_HEIGHT_DEF,
	parameter int MAX_STEPS     = grcs_pkg::MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// column_index[7:0], pos_x[23:8], pos_y[39:24], dir_x[55:40], dir_y[71:56]
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_column[7:0], row_index[13:8], char_code[29:14], zero[31:30]
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import grcs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MARCH, ST_MUL_START, ST_MUL_WAIT, ST_FAR, ST_CSEL,
		ST_DIV_INIT, ST_DIV, ST_EMIT
	} state_t;

	localparam logic [3:0] OP_SQX0 = 4'd0;
	localparam logic [3:0] OP_SQX1 = 4'd1;
	localparam logic [3:0] OP_SQY0 = 4'd2;
	localparam logic [3:0] OP_SQY1 = 4'd3;
	localparam logic [3:0] OP_E0   = 4'd4;
	localparam logic [3:0] OP_E1   = 4'd5;
	localparam logic [3:0] OP_PDX0 = 4'd6;
	localparam logic [3:0] OP_PDX1 = 4'd7;
	localparam logic [3:0] OP_PDY0 = 4'd8;
	localparam logic [3:0] OP_PDY1 = 4'd9;
	localparam logic [3:0] OP_D2   = 4'd10;
	localparam logic [3:0] OP_EV   = 4'd11;
	localparam logic [3:0] OP_EVK  = 4'd12;

	localparam logic signed [19:0] CELL    = 20'(CELL_UNITS);
	localparam logic signed [5:0]  MAP_LIM = 6'(MAP_SIZE);
	localparam logic [7:0]         NMAX    = 8'(MAX_STEPS);
	localparam logic [5:0]         LAST_Y  = 6'(SCREEN_HEIGHT - 1);
	localparam logic [11:0]        H12     = 12'(SCREEN_HEIGHT);

	state_t state_q;

	logic [63:0] map_q [4];
	logic [7:0]  col_q;
	logic [15:0] px_q, py_q;
	logic signed [15:0] dx_q, dy_q;
	logic [17:0] remx_q, remy_q;
	logic signed [5:0] cx_q, cy_q;
	logic [7:0]  n_q;
	logic [3:0]  op_q;
	logic [1:0]  k_q, far_q;
	logic        boundary_q;
	logic [33:0] sqx_q [2];
	logic [33:0] sqy_q [2];
	logic [31:0] e_q;
	logic signed [34:0] pdx_q [2];
	logic signed [34:0] pdy_q [2];
	logic [65:0] d2_q, ev_q;
	logic [8:0]  den_q;
	logic [9:0]  drem_q;
	logic [13:0] quo_q;
	logic        dneg_q;
	logic [3:0]  dcnt_q;
	logic [15:0] shade_q;
	logic [5:0]  y_q;
	logic        m_valid_q;
	logic [7:0]  m_col_q;
	logic [5:0]  m_row_q;
	logic [15:0] m_char_q;
	logic        m_last_q;

	// march step
	logic [255:0] map_flat;
	logic signed [19:0] sumx, sumy;
	logic [17:0] nremx, nremy;
	logic signed [5:0] ncx, ncy;
	logic        off_map, wall;
	logic [7:0]  n_next;

	assign map_flat = {map_q[3], map_q[2], map_q[1], map_q[0]};
	assign sumx = $signed({2'b00, remx_q}) + {{4{dx_q[15]}}, dx_q};
	assign sumy = $signed({2'b00, remy_q}) + {{4{dy_q[15]}}, dy_q};
	assign n_next = n_q + 8'd1;

	always_comb begin
		if (sumx < 0) begin
			nremx = 18'(sumx + CELL);
			ncx   = cx_q - 6'sd1;
		end else if (sumx >= CELL) begin
			nremx = 18'(sumx - CELL);
			ncx   = cx_q + 6'sd1;
		end else begin
			nremx = 18'(sumx);
			ncx   = cx_q;
		end
		if (sumy < 0) begin
			nremy = 18'(sumy + CELL);
			ncy   = cy_q - 6'sd1;
		end else if (sumy >= CELL) begin
			nremy = 18'(sumy - CELL);
			ncy   = cy_q + 6'sd1;
		end else begin
			nremy = 18'(sumy);
			ncy   = cy_q;
		end
	end

	assign off_map = (ncx < 0) || (ncy < 0) || (ncx >= MAP_LIM) || (ncy >= MAP_LIM);
	assign wall    = map_flat[{ncy[3:0], ncx[3:0]}];

	// corner vectors of the hit cell
	logic signed [17:0] vx0, vx1, vy0, vy1;
	logic [17:0] mvx0, mvx1, mvy0, mvy1;
	logic [15:0] mdx, mdy;

	assign vx0 = $signed({2'b00, cx_q[3:0], 12'h000}) - $signed({2'b00, px_q});
	assign vy0 = $signed({2'b00, cy_q[3:0], 12'h000}) - $signed({2'b00, py_q});
	assign vx1 = vx0 + 18'sd4096;
	assign vy1 = vy0 + 18'sd4096;
	assign mvx0 = vx0[17] ? 18'(-vx0) : 18'(vx0);
	assign mvx1 = vx1[17] ? 18'(-vx1) : 18'(vx1);
	assign mvy0 = vy0[17] ? 18'(-vy0) : 18'(vy0);
	assign mvy1 = vy1[17] ? 18'(-vy1) : 18'(vy1);
	assign mdx  = dx_q[15] ? 16'(-dx_q) : 16'(dx_q);
	assign mdy  = dy_q[15] ? 16'(-dy_q) : 16'(dy_q);

	logic signed [35:0] dot_k;
	logic [35:0] mdot_k;
	logic [33:0] v_k;

	assign dot_k  = {pdx_q[k_q[1]][34], pdx_q[k_q[1]]} + {pdy_q[k_q[0]][34], pdy_q[k_q[0]]};
	assign mdot_k = dot_k[35] ? 36'(-dot_k) : 36'(dot_k);
	assign v_k    = sqx_q[k_q[1]] + sqy_q[k_q[0]];

	// farthest corner, ties to the later one
	logic [1:0]  far_c;
	logic [33:0] best_c;
	logic [33:0] vv;
	always_comb begin
		far_c  = 2'd0;
		best_c = '0;
		for (int k = 0; k < 4; k++) begin
			vv = sqx_q[k >> 1] + sqy_q[k & 1];
			if (k == 0 || vv >= best_c) begin
				best_c = vv;
				far_c  = 2'(k);
			end
		end
	end

	// shared multiplier
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic              mul_neg;
	logic              mul_start, mul_busy, mul_done;
	logic [MUL_PW-1:0] mul_p, mul_sp;

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (op_q)
			OP_SQX0: begin mul_a = MUL_AW'(mvx0); mul_b = MUL_BW'(mvx0); end
			OP_SQX1: begin mul_a = MUL_AW'(mvx1); mul_b = MUL_BW'(mvx1); end
			OP_SQY0: begin mul_a = MUL_AW'(mvy0); mul_b = MUL_BW'(mvy0); end
			OP_SQY1: begin mul_a = MUL_AW'(mvy1); mul_b = MUL_BW'(mvy1); end
			OP_E0:   begin mul_a = MUL_AW'(mdx); mul_b = MUL_BW'(mdx); end
			OP_E1:   begin mul_a = MUL_AW'(mdy); mul_b = MUL_BW'(mdy); end
			OP_PDX0: begin
				mul_a = MUL_AW'(mvx0); mul_b = MUL_BW'(mdx); mul_neg = vx0[17] ^ dx_q[15];
			end
			OP_PDX1: begin
				mul_a = MUL_AW'(mvx1); mul_b = MUL_BW'(mdx); mul_neg = vx1[17] ^ dx_q[15];
			end
			OP_PDY0: begin
				mul_a = MUL_AW'(mvy0); mul_b = MUL_BW'(mdy); mul_neg = vy0[17] ^ dy_q[15];
			end
			OP_PDY1: begin
				mul_a = MUL_AW'(mvy1); mul_b = MUL_BW'(mdy); mul_neg = vy1[17] ^ dy_q[15];
			end
			OP_D2:   begin mul_a = MUL_AW'(mdot_k); mul_b = MUL_BW'(mdot_k); end
			OP_EV:   begin mul_a = MUL_AW'(v_k); mul_b = MUL_BW'(e_q); end
			OP_EVK:  begin mul_a = ev_q; mul_b = MUL_BW'(COS2_Q32); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_start = (state_q == ST_MUL_START);
	assign mul_sp    = mul_neg ? MUL_PW'(-mul_p) : mul_p;

	grcs_mul #(
		.AW(MUL_AW),
		.BW(MUL_BW)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.busy(mul_busy),
		.done(mul_done),
		.product(mul_p)
	);

	logic [MUL_PW-1:0] lhs;
	logic              near;
	assign lhs  = MUL_PW'({d2_q, 32'h0000_0000});
	assign near = lhs > mul_p;

	// ceiling setup and divide step
	logic [7:0]  ndiff;
	logic [13:0] num;
	logic [9:0]  rem_sh;
	logic [9:0]  n4, n3, n2;
	logic [15:0] shade_c;

	assign ndiff  = (n_q < 8'd20) ? (8'd20 - n_q) : (n_q - 8'd20);
	assign num    = 14'(14'(ndiff) * 14'(SCREEN_HEIGHT));
	assign rem_sh = {drem_q[8:0], quo_q[13]};
	assign n4 = {n_q, 2'b00};
	assign n3 = {2'b00, n_q} + {1'b0, n_q, 1'b0};
	assign n2 = {1'b0, n_q, 1'b0};

	always_comb begin
		if (boundary_q) begin
			shade_c = CH_SPACE;
		end else if (n4 <= 10'(MAX_STEPS)) begin
			shade_c = CH_FULL;
		end else if (n3 <= 10'(MAX_STEPS)) begin
			shade_c = CH_DARK;
		end else if (n2 <= 10'(MAX_STEPS)) begin
			shade_c = CH_MED;
		end else begin
			shade_c = CH_LIGHT;
		end
	end

	// row character
	logic signed [11:0] ceil_row, floor_row, ys;
	logic [11:0] r12;
	logic [15:0] row_char;

	assign ceil_row  = dneg_q ? -$signed({1'b0, quo_q[10:0]}) : $signed({1'b0, quo_q[10:0]});
	assign floor_row = $signed(H12) - ceil_row;
	assign ys        = $signed({6'b000000, y_q});
	assign r12       = H12 - {6'b000000, y_q};

	always_comb begin
		if (ys < ceil_row) begin
			row_char = CH_SPACE;
		end else if (ys <= floor_row) begin
			row_char = shade_q;
		end else if ((r12 << 3) < H12) begin
			row_char = CH_HASH;
		end else if ((r12 << 2) < H12) begin
			row_char = CH_X;
		end else if ((r12 << 3) < 12'(H12 * 12'd3)) begin
			row_char = CH_DOT;
		end else if (12'(r12 * 12'd20) < 12'(H12 * 12'd9)) begin
			row_char = CH_DASH;
		end else begin
			row_char = CH_SPACE;
		end
	end

	logic out_load;
	assign out_load = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < 4; i++) map_q[i] <= '0;
			col_q      <= '0;
			px_q       <= '0;
			py_q       <= '0;
			dx_q       <= '0;
			dy_q       <= '0;
			remx_q     <= '0;
			remy_q     <= '0;
			cx_q       <= '0;
			cy_q       <= '0;
			n_q        <= '0;
			op_q       <= OP_SQX0;
			k_q        <= '0;
			far_q      <= '0;
			boundary_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				sqx_q[i] <= '0;
				sqy_q[i] <= '0;
				pdx_q[i] <= '0;
				pdy_q[i] <= '0;
			end
			e_q        <= '0;
			d2_q       <= '0;
			ev_q       <= '0;
			den_q      <= '0;
			drem_q     <= '0;
			quo_q      <= '0;
			dneg_q     <= 1'b0;
			dcnt_q     <= '0;
			shade_q    <= CH_SPACE;
			y_q        <= '0;
			m_valid_q  <= 1'b0;
			m_col_q    <= '0;
			m_row_q    <= '0;
			m_char_q   <= '0;
			m_last_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index < 3'd4) begin
				map_q[cfg_index[1:0]] <= cfg_data;
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
				m_col_q   <= col_q;
				m_row_q   <= y_q;
				m_char_q  <= row_char;
				m_last_q  <= (y_q == LAST_Y);
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						col_q      <= s_axis_tdata[7:0];
						px_q       <= s_axis_tdata[23:8];
						py_q       <= s_axis_tdata[39:24];
						dx_q       <= s_axis_tdata[55:40];
						dy_q       <= s_axis_tdata[71:56];
						remx_q     <= 18'({s_axis_tdata[19:8], 5'b0}) +
							18'({s_axis_tdata[19:8], 3'b0});
						remy_q     <= 18'({s_axis_tdata[35:24], 5'b0}) +
							18'({s_axis_tdata[35:24], 3'b0});
						cx_q       <= $signed({2'b00, s_axis_tdata[23:20]});
						cy_q       <= $signed({2'b00, s_axis_tdata[39:36]});
						n_q        <= '0;
						boundary_q <= 1'b0;
						state_q    <= ST_MARCH;
					end
				end
				ST_MARCH: begin
					remx_q <= nremx;
					remy_q <= nremy;
					cx_q   <= ncx;
					cy_q   <= ncy;
					if (off_map) begin
						n_q     <= NMAX;
						state_q <= ST_DIV_INIT;
					end else if (wall) begin
						n_q     <= n_next;
						op_q    <= OP_SQX0;
						state_q <= ST_MUL_START;
					end else if (n_next == NMAX) begin
						n_q     <= NMAX;
						state_q <= ST_DIV_INIT;
					end else begin
						n_q <= n_next;
					end
				end
				ST_MUL_START: begin
					state_q <= ST_MUL_WAIT;
				end
				ST_MUL_WAIT: begin
					if (mul_done) begin
						state_q <= ST_MUL_START;
						op_q    <= op_q + 4'd1;
						case (op_q)
							OP_SQX0: sqx_q[0] <= mul_p[33:0];
							OP_SQX1: sqx_q[1] <= mul_p[33:0];
							OP_SQY0: sqy_q[0] <= mul_p[33:0];
							OP_SQY1: sqy_q[1] <= mul_p[33:0];
							OP_E0:   e_q <= mul_p[31:0];
							OP_E1:   e_q <= e_q + mul_p[31:0];
							OP_PDX0: pdx_q[0] <= $signed(mul_sp[34:0]);
							OP_PDX1: pdx_q[1] <= $signed(mul_sp[34:0]);
							OP_PDY0: pdy_q[0] <= $signed(mul_sp[34:0]);
							OP_PDY1: begin
								pdy_q[1] <= $signed(mul_sp[34:0]);
								state_q  <= ST_FAR;
							end
							OP_D2:   d2_q <= mul_p[65:0];
							OP_EV:   ev_q <= mul_p[65:0];
							OP_EVK: begin
								boundary_q <= boundary_q | near;
								if (k_q == 2'd3) begin
									state_q <= ST_DIV_INIT;
								end else begin
									k_q     <= k_q + 2'd1;
									state_q <= ST_CSEL;
								end
							end
							default: state_q <= ST_DIV_INIT;
						endcase
					end
				end
				ST_FAR: begin
					far_q   <= far_c;
					k_q     <= 2'd0;
					state_q <= ST_CSEL;
				end
				ST_CSEL: begin
					if (k_q != far_q && !dot_k[35] && dot_k != 36'sd0) begin
						op_q    <= OP_D2;
						state_q <= ST_MUL_START;
					end else if (k_q == 2'd3) begin
						state_q <= ST_DIV_INIT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_DIV_INIT: begin
					dneg_q  <= (n_q < 8'd20);
					quo_q   <= num;
					den_q   <= {n_q, 1'b0};
					drem_q  <= '0;
					dcnt_q  <= '0;
					shade_q <= shade_c;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (rem_sh >= {1'b0, den_q}) begin
						drem_q <= rem_sh - {1'b0, den_q};
						quo_q  <= {quo_q[12:0], 1'b1};
					end else begin
						drem_q <= rem_sh;
						quo_q  <= {quo_q[12:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'(DIV_BITS - 1)) begin
						y_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (y_q == LAST_Y) begin
							state_q <= ST_IDLE;
						end else begin
							y_q <= y_q + 6'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE) && arst_n;
	assign cfg_ready     = arst_n;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_char_q, m_row_q, m_col_q};
	assign m_axis_tlast  = m_last_q;

	`GRCS_ASSERT_IMPL(a_tlast_row, m_axis_tvalid, m_axis_tlast == (m_row_q == LAST_Y), "tlast not on last row")
	`GRCS_ASSERT_IMPL(a_steps_bound, state_q != ST_IDLE, n_q <= NMAX, "step count beyond limit")
	`GRCS_ASSERT_IMPL(a_mul_owner, mul_busy, state_q == ST_MUL_WAIT, "multiplier busy outside wait")
	`GRCS_ASSERT_NEXT(a_row_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "row gap inside column")

endmodule
